>>> rtl/selective_repeat_sender_window_macros.svh
// Assertion macros shared by the checker of the sender window
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRSW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sender window check failed");

// Consequent must hold in the cycle after the antecedent
`define SRSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sender window check failed");

`endif

>>> rtl/srsw_pkg.sv
// Shared types and constants of the selective-repeat sender window
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  // Sizing defaults
  localparam int MAX_FRAMES_DEF = 128;
  localparam int MAX_WINDOW_DEF = 64;

  // Field widths
  localparam int FRAME_W = 7;
  localparam int BASE_W  = 8;
  localparam int CFG_W   = 7;
  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Register map: index is the word address bit
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RST  = 7'd127;
  localparam logic [CFG_W-1:0] WINDOW_RST = 7'd8;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUTCOME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START_SCAN,
    ST_END_SCAN
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] total;
    logic [CFG_W-1:0] window;
  } cfg_t;

  typedef struct packed {
    logic begin_start;
    logic begin_outcome;
    logic begin_end;
    logic emit_other;
    logic check;
    logic scan;
    logic scan_end;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/srsw_regs.sv
// APB configuration registers: total frame count and window size
`timescale 1ns / 1ps
`default_nettype none

module srsw_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srsw_pkg::DATA_W-1:0]  pwdata,
  output logic [srsw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output srsw_pkg::cfg_t               cfg
);

  localparam int DW = srsw_pkg::DATA_W;
  localparam int CW = srsw_pkg::CFG_W;

  logic [CW-1:0] total;
  logic [CW-1:0] window;
  logic          wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= srsw_pkg::TOTAL_RST;
      window <= srsw_pkg::WINDOW_RST;
    end else if (wr) begin
      unique case (paddr[srsw_pkg::REG_SEL_BIT])
        srsw_pkg::REG_TOTAL:  total  <= pwdata[CW-1:0];
        srsw_pkg::REG_WINDOW: window <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (paddr[srsw_pkg::REG_SEL_BIT])
      srsw_pkg::REG_TOTAL:  prdata = DW'(total);
      srsw_pkg::REG_WINDOW: prdata = DW'(window);
      default: prdata = '0;
    endcase
  end

  assign cfg.total  = total;
  assign cfg.window = window;

endmodule

`default_nettype wire

>>> rtl/srsw_ctrl.sv
// Controller state machine: sequences accept, outcome check and bitmap scans
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [srsw_pkg::KIND_W-1:0]  kind,
  input  srsw_pkg::status_t            status,
  output logic                         busy,
  output srsw_pkg::cmd_t               cmd
);

  srsw_pkg::state_t state;
  srsw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      srsw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (kind)
            srsw_pkg::KIND_START:   state_next = srsw_pkg::ST_START_SCAN;
            srsw_pkg::KIND_OUTCOME: state_next = srsw_pkg::ST_CHECK;
            srsw_pkg::KIND_END:     state_next = srsw_pkg::ST_END_SCAN;
            default:                state_next = srsw_pkg::ST_IDLE;
          endcase
        end
      end
      srsw_pkg::ST_CHECK: state_next = srsw_pkg::ST_IDLE;
      srsw_pkg::ST_START_SCAN,
      srsw_pkg::ST_END_SCAN: begin
        if (status.scan_done) state_next = srsw_pkg::ST_IDLE;
      end
      default: state_next = srsw_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      srsw_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (kind)
            srsw_pkg::KIND_START:   cmd.begin_start   = 1'b1;
            srsw_pkg::KIND_OUTCOME: cmd.begin_outcome = 1'b1;
            srsw_pkg::KIND_END:     cmd.begin_end     = 1'b1;
            default:                cmd.emit_other    = 1'b1;
          endcase
        end
      end
      srsw_pkg::ST_CHECK: cmd.check = 1'b1;
      srsw_pkg::ST_START_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.finish = status.scan_done;
      end
      srsw_pkg::ST_END_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.scan_end = 1'b1;
        cmd.finish   = status.scan_done;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/srsw_datapath.sv
// Datapath: window state, acknowledge bitmap with registered read, result registers
`timescale 1ns / 1ps
`default_nettype none

module srsw_datapath #(
  parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srsw_pkg::cfg_t                cfg,
  input  srsw_pkg::cmd_t                cmd,
  input  logic [srsw_pkg::FRAME_W-1:0]  frame_number,
  input  logic                          delivered,
  output srsw_pkg::status_t             status,
  output logic                          result_strobe,
  output logic [srsw_pkg::FRAME_W-1:0]  send_frame,
  output logic                          send_valid,
  output logic                          accepted,
  output logic [srsw_pkg::BASE_W-1:0]   window_base,
  output logic [srsw_pkg::FRAME_W-1:0]  window_last,
  output logic                          retransmit_pending,
  output logic                          all_done,
  output logic                          last
);

  localparam int FW        = srsw_pkg::FRAME_W;
  localparam int BW        = srsw_pkg::BASE_W;
  localparam int AW        = $clog2(MAX_FRAMES);
  localparam int TOP_FRAME = MAX_FRAMES - 1;
  localparam int SW        = BW + 1;

  // Window state
  logic [BW-1:0]         base;
  logic [BW-1:0]         round_end;
  logic [MAX_FRAMES-1:0] acked;

  // Scan pipeline
  logic [BW-1:0] ptr;
  logic          running;
  logic          rd_valid;
  logic          rd_data;
  logic [BW-1:0] rd_frame;
  logic [FW-1:0] held_frame;
  logic          held_valid;

  // Latched outcome item
  logic [FW-1:0] cur_frame;
  logic          cur_delivered;

  logic [FW-1:0] eff_total;
  logic [FW-1:0] eff_window;
  logic [SW-1:0] win_raw;
  logic [FW-1:0] win_end;
  logic [BW-1:0] limit;
  logic          issue_ok;
  logic          issue;
  logic          held_take;
  logic [AW-1:0] rd_addr;
  logic          in_window;
  logic          acc;

  logic          emit;
  logic [FW-1:0] e_frame;
  logic          e_valid;
  logic          e_acc;
  logic          e_pend;
  logic          e_last;

  // Effective register values
  always_comb begin
    if (int'(cfg.total) > TOP_FRAME) eff_total = FW'(TOP_FRAME);
    else eff_total = cfg.total;
  end

  always_comb begin
    if (cfg.window == '0) eff_window = FW'(1);
    else if (int'(cfg.window) > MAX_WINDOW) eff_window = FW'(MAX_WINDOW);
    else eff_window = cfg.window;
  end

  // Window end: lesser of base+window-1 and total
  assign win_raw = SW'(base) + SW'(eff_window) - SW'(1);
  assign win_end = (win_raw > SW'(eff_total)) ? eff_total : win_raw[FW-1:0];

  // Scan control
  assign limit     = cmd.scan_end ? BW'(eff_total) : round_end;
  assign issue_ok  = (ptr <= limit) && (!cmd.scan_end || running);
  assign issue     = cmd.scan && issue_ok;
  assign held_take = cmd.scan && !cmd.scan_end && rd_valid && !rd_data;
  assign status.scan_done = !issue_ok && !rd_valid;

  assign rd_addr = cmd.begin_outcome ? AW'(frame_number) : AW'(ptr);

  // Bitmap read port, one address a cycle
  always_ff @(posedge clk) begin
    rd_data  <= acked[rd_addr];
    rd_frame <= ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  // Outcome check
  assign in_window = (BW'(cur_frame) >= base) && (cur_frame <= win_end) &&
                     (cur_frame <= eff_total);
  assign acc = in_window && !rd_data;

  // Bitmap writes
  always_ff @(posedge clk) begin
    if (rst) begin
      acked <= '0;
    end else if (cmd.check && acc && cur_delivered) begin
      acked[AW'(cur_frame)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_outcome) begin
      cur_frame     <= frame_number;
      cur_delivered <= delivered;
    end
  end

  // Scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.begin_start || cmd.begin_end) begin
      ptr <= base;
    end else if (issue) begin
      ptr <= ptr + BW'(1);
    end
  end

  // Base slide stops at the first unacknowledged frame
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      base    <= BW'(1);
    end else if (cmd.begin_end) begin
      running <= 1'b1;
    end else if (cmd.scan_end && running && rd_valid) begin
      if (rd_data) base <= rd_frame + BW'(1);
      else running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_end <= '0;
    end else if (cmd.begin_start) begin
      round_end <= BW'(win_end);
    end
  end

  // One-deep hold so the final frame can be marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.begin_start) begin
      held_valid <= 1'b0;
    end else if (held_take) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take) held_frame <= rd_frame[FW-1:0];
  end

  // Result selection
  always_comb begin
    emit    = 1'b0;
    e_frame = '0;
    e_valid = 1'b0;
    e_acc   = 1'b0;
    e_pend  = 1'b0;
    e_last  = 1'b0;
    if (held_take && held_valid) begin
      emit    = 1'b1;
      e_frame = held_frame;
      e_valid = 1'b1;
    end
    if (cmd.finish) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (cmd.scan_end) begin
        e_pend = (base <= round_end);
      end else if (held_valid) begin
        e_frame = held_frame;
        e_valid = 1'b1;
      end
    end
    if (cmd.check) begin
      emit   = 1'b1;
      e_acc  = acc;
      e_last = 1'b1;
    end
    if (cmd.emit_other) begin
      emit   = 1'b1;
      e_last = 1'b1;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      send_frame         <= e_frame;
      send_valid         <= e_valid;
      accepted           <= e_acc;
      retransmit_pending <= e_pend;
      last               <= e_last;
      window_base        <= base;
      window_last        <= win_end;
      all_done           <= (base > BW'(eff_total));
    end
  end

endmodule

`default_nettype wire

>>> rtl/selective_repeat_sender_window.sv
// Top level of the selective-repeat ARQ sender window
`timescale 1ns / 1ps
`default_nettype none

// Sender window of a selective-repeat ARQ link, frames numbered 1..total_frames.
// An item is taken when start is high and busy is low; each result appears for
// one cycle with result_strobe high and cannot be held off, so the receiver must
// take it then. An outcome item reads the bitmap, then checks and writes it; an
// unused kind is answered straight from idle. A start-round item and an end-round
// item both walk the acknowledge bitmap through its single registered read port,
// one frame a cycle; the end round stops at the first unacknowledged frame or at
// total_frames. Results of a start round come one frame a cycle with gaps where
// frames are already acknowledged. Configuration goes through the APB port at
// byte addresses 0 (total_frames) and 4 (window_size); the user must write it
// only while idle, which the block itself does not enforce.
module selective_repeat_sender_window #(
  parameter int MAX_FRAMES = srsw_pkg::MAX_FRAMES_DEF,
  parameter int MAX_WINDOW = srsw_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [srsw_pkg::KIND_W-1:0]   kind,
  input  logic [srsw_pkg::FRAME_W-1:0]  frame_number,
  input  logic                          delivered,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsw_pkg::ADDR_W-1:0]   paddr,
  input  logic [srsw_pkg::DATA_W-1:0]   pwdata,
  output logic [srsw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic                          result_strobe,
  output logic [srsw_pkg::FRAME_W-1:0]  send_frame,
  output logic                          send_valid,
  output logic                          accepted,
  output logic [srsw_pkg::BASE_W-1:0]   window_base,
  output logic [srsw_pkg::FRAME_W-1:0]  window_last,
  output logic                          retransmit_pending,
  output logic                          all_done,
  output logic                          last
);

  srsw_pkg::cfg_t    cfg;
  srsw_pkg::cmd_t    cmd;
  srsw_pkg::status_t status;

  srsw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srsw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  srsw_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .frame_number       (frame_number),
    .delivered          (delivered),
    .status             (status),
    .result_strobe      (result_strobe),
    .send_frame         (send_frame),
    .send_valid         (send_valid),
    .accepted           (accepted),
    .window_base        (window_base),
    .window_last        (window_last),
    .retransmit_pending (retransmit_pending),
    .all_done           (all_done),
    .last               (last)
  );

endmodule

`default_nettype wire

>>> rtl/srsw_checker.sv
// Port-level checks of the sender window, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "selective_repeat_sender_window_macros.svh"

module srsw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          result_strobe,
  input logic [srsw_pkg::FRAME_W-1:0]  send_frame,
  input logic                          send_valid,
  input logic [srsw_pkg::BASE_W-1:0]   window_base,
  input logic [srsw_pkg::FRAME_W-1:0]  window_last,
  input logic                          all_done,
  input logic                          last
);

  // Only frame listings may leave a run open
  `SRSW_ASSERT_SAME(a_open_is_frame, result_strobe && !last, send_valid)

  // A listed frame lies inside the reported window
  `SRSW_ASSERT_SAME(a_frame_in_window, result_strobe && send_valid, (({1'b0, send_frame} >= window_base) && (send_frame <= window_last)))

  // Nothing is listed once the transfer is complete
  `SRSW_ASSERT_SAME(a_done_no_send, result_strobe && all_done, !send_valid)

  // An accepted item either keeps the block busy or answers at once
  `SRSW_ASSERT_NEXT(a_accept_moves, start && !busy, busy || result_strobe)

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);

`default_nettype wire

>>> test/selective_repeat_sender_window_checker.sv
// Checker for the sender window: predicts every result and compares it as it appears
`timescale 1ns / 1ps

module selective_repeat_sender_window_checker
  import srsw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [FRAME_W-1:0]  frame_number,
  input  logic                delivered,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  input  logic                result_strobe,
  input  logic [FRAME_W-1:0]  send_frame,
  input  logic                send_valid,
  input  logic                accepted,
  input  logic [BASE_W-1:0]   window_base,
  input  logic [FRAME_W-1:0]  window_last,
  input  logic                retransmit_pending,
  input  logic                all_done,
  input  logic                last,
  output int                  fail_count,
  output int                  waiting,
  output int                  seen_base,
  output int                  seen_end
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               valid;
    logic               acc;
    logic [BASE_W-1:0]  base;
    logic [FRAME_W-1:0] wlast;
    logic               pend;
    logic               done;
    logic               fin;
  } window_result_t;

  // Shadow of the sender state and registers
  logic [CFG_W-1:0] tot_reg;
  logic [CFG_W-1:0] win_reg;
  int               head;
  int               round_end;
  bit               acked [MAX_FRAMES_DEF];
  window_result_t   due_results [$];
  int               fails = 0;

  assign fail_count = fails;

  // Window end: window clamped to 1..MAX_WINDOW, end clipped at the total
  function automatic int span_end();
    int w;
    int e;
    w = (win_reg == 0) ? 1 : int'(win_reg);
    if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
    e = head + w - 1;
    return (e > int'(tot_reg)) ? int'(tot_reg) : e;
  endfunction

  function automatic window_result_t make_result(int frame, bit valid, bit acc, bit pend,
                                                 bit fin);
    window_result_t r;
    int stop;
    stop    = span_end();
    r.frame = FRAME_W'(frame);
    r.valid = valid;
    r.acc   = acc;
    r.base  = BASE_W'(head);
    r.wlast = FRAME_W'(stop);
    r.pend  = pend;
    r.done  = (head > int'(tot_reg));
    r.fin   = fin;
    return r;
  endfunction

  // Apply one accepted item and queue the results it causes
  task automatic advance_window(logic [KIND_W-1:0] k, logic [FRAME_W-1:0] f, logic d);
    int stop;
    int n;
    bit acc;
    window_result_t r;
    stop = span_end();
    n = 0;
    case (k)
      KIND_START: begin
        round_end = stop;
        for (int i = head; i <= stop; i++) begin
          if (!acked[i]) begin
            due_results.push_back(make_result(i, 1'b1, 1'b0, 1'b0, 1'b0));
            n++;
          end
        end
        if (n == 0) begin
          due_results.push_back(make_result(0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          r = due_results[due_results.size()-1];
          r.fin = 1'b1;
          due_results[due_results.size()-1] = r;
        end
      end
      KIND_OUTCOME: begin
        acc = (int'(f) >= head) && (int'(f) <= stop) && (f <= tot_reg) && !acked[f];
        if (acc && d) acked[f] = 1'b1;
        due_results.push_back(make_result(0, 1'b0, acc, 1'b0, 1'b1));
      end
      KIND_END: begin
        while (head <= int'(tot_reg) && acked[head]) head++;
        due_results.push_back(make_result(0, 1'b0, 1'b0, head <= round_end, 1'b1));
      end
      default: begin
        due_results.push_back(make_result(0, 1'b0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      tot_reg   = TOTAL_RST;
      win_reg   = WINDOW_RST;
      head      = 1;
      round_end = 0;
      foreach (acked[i]) acked[i] = 1'b0;
      due_results.delete();
    end else begin
      // Results first: they belong to items taken at earlier edges
      if (result_strobe) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none actual frame %0d", $time,
                   send_frame);
        end else begin
          want = due_results.pop_front();
          check_field("send_frame", want.frame, send_frame);
          check_field("send_valid", want.valid, send_valid);
          check_field("accepted", want.acc, accepted);
          check_field("window_base", want.base, window_base);
          check_field("window_last", want.wlast, window_last);
          check_field("retransmit_pending", want.pend, retransmit_pending);
          check_field("all_done", want.done, all_done);
          check_field("last", want.fin, last);
        end
      end
      // Register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[REG_SEL_BIT] == REG_WINDOW) win_reg = pwdata[CFG_W-1:0];
          else tot_reg = pwdata[CFG_W-1:0];
        end else begin
          check_field("register readback",
                      (paddr[REG_SEL_BIT] == REG_WINDOW) ? win_reg : tot_reg,
                      prdata[CFG_W-1:0]);
        end
      end
      if (start && !busy) advance_window(kind, frame_number, delivered);
    end
    // Registered copies for the stimulus side
    waiting   <= due_results.size();
    seen_base <= head;
    seen_end  <= span_end();
  end

endmodule

>>> test/selective_repeat_sender_window_tb.sv
// Testbench top: stimulus, register setup and verdict for the sender window
`timescale 1ns / 1ps

module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int ITEM_BUDGET = 120;
  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [KIND_W-1:0]   kind = KIND_START;
  logic [FRAME_W-1:0]  frame_number = '0;
  logic                delivered = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;

  logic                busy;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                result_strobe;
  logic [FRAME_W-1:0]  send_frame;
  logic                send_valid;
  logic                accepted;
  logic [BASE_W-1:0]   window_base;
  logic [FRAME_W-1:0]  window_last;
  logic                retransmit_pending;
  logic                all_done;
  logic                last;

  int fail_count;
  int waiting;
  int seen_base;
  int seen_end;
  int cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;

  always #4 clk = ~clk;

  selective_repeat_sender_window u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .frame_number(frame_number), .delivered(delivered),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .result_strobe(result_strobe), .send_frame(send_frame), .send_valid(send_valid),
    .accepted(accepted), .window_base(window_base), .window_last(window_last),
    .retransmit_pending(retransmit_pending), .all_done(all_done), .last(last)
  );

  selective_repeat_sender_window_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .frame_number(frame_number), .delivered(delivered),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .result_strobe(result_strobe), .send_frame(send_frame), .send_valid(send_valid),
    .accepted(accepted), .window_base(window_base), .window_last(window_last),
    .retransmit_pending(retransmit_pending), .all_done(all_done), .last(last),
    .fail_count(fail_count), .waiting(waiting), .seen_base(seen_base),
    .seen_end(seen_end)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** selective_repeat_sender_window: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until taken; start stays high unless a gap follows
  task automatic send_item(logic [KIND_W-1:0] k, logic [FRAME_W-1:0] f, logic d);
    int gap;
    kind         <= k;
    frame_number <= f;
    delivered    <= d;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0 || busy) @(posedge clk);
  endtask

  // Write both registers and read each back; only called when idle
  task automatic configure(int total, int window);
    logic [DATA_W-1:0] val [2];
    logic              sel [2];
    val[0] = {25'($urandom_range(0, 32'h01FF_FFFF)), 7'(total)};
    val[1] = {25'($urandom_range(0, 32'h01FF_FFFF)), 7'(window)};
    sel[0] = REG_TOTAL;
    sel[1] = REG_WINDOW;
    for (int a = 0; a < 4; a++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (a % 2 == 0);
      paddr   <= ADDR_W'(sel[a / 2]) << REG_SEL_BIT;
      pwdata  <= (a % 2 == 0) ? val[a / 2] : '0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int lo;
    int hi;
    int cur_total;
    int n;
    int r;
    int f;
    int rounds;
    int new_window;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: end round with no start round yet, spare kind, out-of-window outcomes
    send_item(KIND_END, 7'd85, 1'b1);
    send_item(KIND_SPARE, 7'd42, 1'b0);
    send_item(KIND_OUTCOME, 7'd0, 1'b1);
    send_item(KIND_OUTCOME, 7'd127, 1'b1);
    // Full window of eight, lost frame, duplicate ack, frame past window end
    send_item(KIND_START, 7'd0, 1'b0);
    send_item(KIND_OUTCOME, 7'd1, 1'b0);
    send_item(KIND_OUTCOME, 7'd2, 1'b1);
    send_item(KIND_OUTCOME, 7'd2, 1'b1);
    send_item(KIND_OUTCOME, 7'd1, 1'b1);
    send_item(KIND_OUTCOME, 7'd9, 1'b1);
    send_item(KIND_OUTCOME, 7'd8, 1'b1);
    send_item(KIND_START, 7'd127, 1'b1);
    send_item(KIND_END, 7'd0, 1'b0);
    // Oversized window clipped by a small total, then completion
    drain();
    configure(5, 127);
    send_item(KIND_START, 7'd3, 1'b0);
    send_item(KIND_OUTCOME, 7'd3, 1'b1);
    send_item(KIND_OUTCOME, 7'd4, 1'b1);
    send_item(KIND_OUTCOME, 7'd5, 1'b1);
    send_item(KIND_END, 7'd64, 1'b1);
    send_item(KIND_START, 7'd1, 1'b1);
    send_item(KIND_OUTCOME, 7'd5, 1'b1);
    // Zero total and zero window
    drain();
    configure(0, 0);
    send_item(KIND_START, 7'd0, 1'b0);
    send_item(KIND_END, 7'd0, 1'b0);

    // Random rounds, starting with the widest window
    drain();
    configure(127, 64);
    cur_total  = 127;
    rounds     = 0;
    lo         = 1;
    hi         = 0;
    while (items_sent < ITEM_BUDGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (rounds != 0 && (rounds % 4 == 0 || lo > hi)) begin
        drain();
        case ($urandom_range(0, 7))
          0: new_window = 1;
          1: new_window = 64;
          2: new_window = 0;
          3: new_window = 127;
          default: new_window = $urandom_range(2, 16);
        endcase
        if (lo > 127) cur_total = $urandom_range(0, 127);
        else if ($urandom_range(0, 4) == 0) cur_total = 127;
        else if (lo > hi) cur_total = (lo - 1 + $urandom_range(5, 25) > 127) ? 127 :
                                      lo - 1 + $urandom_range(5, 25);
        configure(cur_total, new_window);
      end
      send_item(KIND_START, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      lo = seen_base;
      hi = seen_end;
      n  = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80 && hi >= lo) begin
          f = lo + $urandom_range(0, (hi - lo > 7) ? 7 : hi - lo);
          send_item(KIND_OUTCOME, 7'(f), ($urandom_range(0, 3) != 0));
        end else if (r < 92) begin
          send_item(KIND_OUTCOME, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end else begin
          send_item(KIND_SPARE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
      end
      // Broken rounds: now and then no end round, or a second one
      r = $urandom_range(0, 9);
      if (r != 0) send_item(KIND_END, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      if (r == 1) send_item(KIND_END, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      // Hold off once until everything outstanding has come back
      if (rounds == 2) drain();
      rounds++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** selective_repeat_sender_window: PASSED **");
    end else begin
      $display("** selective_repeat_sender_window: FAILED **");
    end
    $finish;
  end

endmodule
